// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hdl/twrq_pkg.sv
// ----------------------------------------------------------------------------
// twrq_pkg
// Shared widths, request codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package twrq_pkg;

   localparam int ID_W  = 6;
   localparam int POS_W = 64;
   localparam int REQ_W = 2;

   localparam logic [POS_W-1:0] UINT64_MAX = {POS_W{1'b1}};

   typedef enum logic [REQ_W-1:0] {
      REQ_ADD     = 2'd0,
      REQ_REMOVE  = 2'd1,
      REQ_ADVANCE = 2'd2,
      REQ_NONE    = 2'd3
   } req_code_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;        // request word taken this cycle
      logic scan_start;    // begin a min search over the table
      logic release_best;  // retire the current best waiter and rescan
      logic load_done;     // load a plain (no release) result word
      logic load_rel;      // load a release result word
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done;     // search finished, best registers final
      logic releasable;    // best waiter is due at the held position, or that position is zero
      logic rsp_free;      // result register can take a word
   } status_type;

endpackage

// File: hdl/twrq_req_if.sv
// ----------------------------------------------------------------------------
// twrq_req_if
// Request channel: valid/ready with one request word.
// ----------------------------------------------------------------------------
interface twrq_req_if import twrq_pkg::*; ();

   logic                 valid;
   logic                 ready;
   logic [REQ_W-1:0]     req_type;
   logic [ID_W-1:0]      waiter_id;
   logic [POS_W-1:0]     position;

   modport source (output valid, output req_type, output waiter_id, output position,
                   input ready);
   modport sink   (input valid, input req_type, input waiter_id, input position,
                   output ready);

endinterface

// File: hdl/twrq_rsp_if.sv
// ----------------------------------------------------------------------------
// twrq_rsp_if
// Result channel: valid/ready with one result word.
// ----------------------------------------------------------------------------
interface twrq_rsp_if import twrq_pkg::*; ();

   logic                 valid;
   logic                 ready;
   logic [ID_W-1:0]      woken_id;
   logic                 woken_valid;
   logic [POS_W-1:0]     min_waiting;
   logic                 error_flag;
   logic                 last_result;

   modport source (output valid, output woken_id, output woken_valid, output min_waiting,
                   output error_flag, output last_result, input ready);
   modport sink   (input valid, input woken_id, input woken_valid, input min_waiting,
                   input error_flag, input last_result, output ready);

endinterface

// File: hdl/twrq_datapath.sv
// ----------------------------------------------------------------------------
// twrq_datapath
// Target memory, enrolled flags, sequential min search and result register.
// ----------------------------------------------------------------------------
module twrq_datapath import twrq_pkg::*; #(
   parameter int MAX_WAITERS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [REQ_W-1:0]   req_type,
   input  logic [ID_W-1:0]    req_waiter_id,
   input  logic [POS_W-1:0]   req_position,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [ID_W-1:0]    rsp_woken_id,
   output logic               rsp_woken_valid,
   output logic [POS_W-1:0]   rsp_min_waiting,
   output logic               rsp_error_flag,
   output logic               rsp_last_result
);

   localparam int IDW  = $clog2(MAX_WAITERS);
   localparam int CNTW = $clog2(MAX_WAITERS + 1);

   logic [POS_W-1:0]       target_mem [MAX_WAITERS];

   logic [MAX_WAITERS-1:0] enrolled_ff, enrolled_in;
   logic [POS_W-1:0]       min_ff, min_in;
   logic                   err_ff, err_in;
   logic [POS_W-1:0]       pos_ff;

   logic [CNTW-1:0]        cnt_ff, cnt_in;
   logic                   active_ff, active_in;
   logic                   pipe_vld_ff;
   logic                   pipe_en_ff;
   logic [IDW-1:0]         pipe_id_ff;
   logic [POS_W-1:0]       rd_data_ff;
   logic                   done_ff, done_in;
   logic                   best_found_ff, best_found_in;
   logic [POS_W-1:0]       best_val_ff, best_val_in;
   logic [IDW-1:0]         best_id_ff, best_id_in;
   logic [IDW-1:0]         rel_id_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]        rsp_id_ff;
   logic                   rsp_wv_ff;
   logic [POS_W-1:0]       rsp_min_ff;
   logic                   rsp_err_ff;
   logic                   rsp_last_ff;

   logic                   id_ok;
   logic [IDW-1:0]         widx;
   logic [IDW-1:0]         ridx;
   logic                   is_add, is_rem;
   logic                   mem_we;
   logic                   issue;
   logic                   take;
   logic                   releasable;
   logic                   rsp_free;

   assign id_ok   = {1'b0, req_waiter_id} < (ID_W + 1)'(MAX_WAITERS);
   assign widx    = req_waiter_id[IDW-1:0];
   assign ridx    = cnt_ff[IDW-1:0];
   assign is_add  = cmd.accept && (req_type == REQ_ADD);
   assign is_rem  = cmd.accept && (req_type == REQ_REMOVE);
   assign mem_we  = is_add && id_ok && !enrolled_ff[widx];
   assign issue   = active_ff && (cnt_ff != CNTW'(MAX_WAITERS));
   assign take    = pipe_vld_ff && pipe_en_ff && (!best_found_ff || rd_data_ff < best_val_ff);
   assign releasable = best_found_ff && ((pos_ff == '0) || (best_val_ff <= pos_ff));
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      enrolled_in = enrolled_ff;
      if (mem_we) begin
         enrolled_in[widx] = 1'b1;
      end
      if (is_rem && id_ok) begin
         enrolled_in[widx] = 1'b0;
      end
      if (cmd.release_best) begin
         enrolled_in[best_id_ff] = 1'b0;
      end

      min_in = min_ff;
      if (mem_we && (req_position < min_ff)) begin
         min_in = req_position;
      end else if (done_ff) begin
         min_in = best_found_ff ? best_val_ff : UINT64_MAX;
      end

      err_in = cmd.accept ? (is_add && id_ok && enrolled_ff[widx]) : err_ff;

      // search sequencing
      done_in   = active_ff && !issue && !pipe_vld_ff;
      active_in = active_ff;
      cnt_in    = cnt_ff;
      if (cmd.scan_start || cmd.release_best) begin
         active_in = 1'b1;
         cnt_in    = '0;
      end else begin
         if (done_in) begin
            active_in = 1'b0;
         end
         if (issue) begin
            cnt_in = cnt_ff + CNTW'(1);
         end
      end

      best_found_in = best_found_ff;
      best_val_in   = best_val_ff;
      best_id_in    = best_id_ff;
      if (cmd.scan_start || cmd.release_best) begin
         best_found_in = 1'b0;
      end else if (take) begin
         best_found_in = 1'b1;
         best_val_in   = rd_data_ff;
         best_id_in    = pipe_id_ff;
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_done || cmd.load_rel) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         enrolled_ff   <= '0;
         min_ff        <= UINT64_MAX;
         active_ff     <= 1'b0;
         pipe_vld_ff   <= 1'b0;
         done_ff       <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         enrolled_ff   <= enrolled_in;
         min_ff        <= min_in;
         active_ff     <= active_in;
         pipe_vld_ff   <= issue;
         done_ff       <= done_in && !(cmd.scan_start || cmd.release_best);
         best_found_ff <= best_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      err_ff      <= err_in;
      pipe_en_ff  <= enrolled_ff[ridx];
      pipe_id_ff  <= ridx;
      best_val_ff <= best_val_in;
      best_id_ff  <= best_id_in;
      if (cmd.accept) begin
         pos_ff <= req_position;
      end
      if (cmd.release_best) begin
         rel_id_ff <= best_id_ff;
      end
      if (cmd.load_done) begin
         rsp_id_ff   <= '0;
         rsp_wv_ff   <= 1'b0;
         rsp_min_ff  <= min_ff;
         rsp_err_ff  <= err_ff;
         rsp_last_ff <= 1'b1;
      end else if (cmd.load_rel) begin
         rsp_id_ff   <= ID_W'(rel_id_ff);
         rsp_wv_ff   <= 1'b1;
         rsp_min_ff  <= min_ff;
         rsp_err_ff  <= 1'b0;
         rsp_last_ff <= !releasable;
      end
   end

   // target memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         target_mem[widx] <= req_position;
      end
      rd_data_ff <= target_mem[ridx];
   end

   assign status.scan_done  = done_ff;
   assign status.releasable = releasable;
   assign status.rsp_free   = rsp_free;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_woken_id    = rsp_id_ff;
   assign rsp_woken_valid = rsp_wv_ff;
   assign rsp_min_waiting = rsp_min_ff;
   assign rsp_error_flag  = rsp_err_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

// File: hdl/twrq_ctrl.sv
// ----------------------------------------------------------------------------
// twrq_ctrl
// Request sequencer: search, release and result loading.
// ----------------------------------------------------------------------------
module twrq_ctrl import twrq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [REQ_W-1:0]  req_type,
   output logic              req_ready,
   input  status_type        status,
   output cmd_type           cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_REM,
      S_SCAN_ADV,
      S_SCAN_REL,
      S_EMIT_REL,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.accept = 1'b1;
               case (req_type)
                  REQ_REMOVE: begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN_REM;
                  end
                  REQ_ADVANCE: begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN_ADV;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SCAN_REM: begin
            if (status.scan_done) begin
               state_in = S_DONE;
            end
         end
         S_SCAN_ADV: begin
            if (status.scan_done) begin
               if (status.releasable) begin
                  cmd.release_best = 1'b1;
                  state_in         = S_SCAN_REL;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN_REL: begin
            if (status.scan_done) begin
               state_in = S_EMIT_REL;
            end
         end
         S_EMIT_REL: begin
            if (status.rsp_free) begin
               cmd.load_rel = 1'b1;
               if (status.releasable) begin
                  cmd.release_best = 1'b1;
                  state_in         = S_SCAN_REL;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.load_done = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

   assign req_ready = ready_ff;

endmodule

// File: hdl/threshold_waiter_release_queue_core.sv
// ----------------------------------------------------------------------------
// threshold_waiter_release_queue_core: waiters released in target order
// One request in flight; the last result word is loaded before the next request
// is taken. Add/unknown need no table search, remove needs one, and an advance
// releasing k needs k+1: the first search plus one rescan per release.
// Sync reset: table empty, min all ones; target memory contents not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module threshold_waiter_release_queue_core import twrq_pkg::*; #(
   parameter int MAX_WAITERS = 64
) (
   input  logic         clock,
   input  logic         reset,
   twrq_req_if.sink     req_if,
   twrq_rsp_if.source   rsp_if
);

   // The controller owns the request handshake and sequences the datapath.
   // The datapath owns the target memory, the enrolled flags, the running
   // minimum and the result register, so the result word can sit waiting
   // while the controller already searches for the next release.
   cmd_type    cmd;
   status_type status;

   twrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_type  (req_if.req_type),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Search pass: reads one memory entry per cycle with registered data,
   // keeps the smallest enrolled target (strict compare, so the lowest id
   // wins a tie). An advance retires the best waiter and rescans to find
   // both the new minimum for that word and the next candidate.
   twrq_datapath #(
      .MAX_WAITERS (MAX_WAITERS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_type        (req_if.req_type),
      .req_waiter_id   (req_if.waiter_id),
      .req_position    (req_if.position),
      .cmd             (cmd),
      .status          (status),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_woken_id    (rsp_if.woken_id),
      .rsp_woken_valid (rsp_if.woken_valid),
      .rsp_min_waiting (rsp_if.min_waiting),
      .rsp_error_flag  (rsp_if.error_flag),
      .rsp_last_result (rsp_if.last_result)
   );

   // one request at a time: the port closes right after a word is taken
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_if.valid && req_if.ready, !req_if.ready)
   // a release word never carries the duplicate-add error
   `ASSERT_SAME(a_release_no_err, clock, reset, rsp_if.valid && rsp_if.woken_valid,
                !rsp_if.error_flag)
   // an error word always ends its request
   `ASSERT_SAME(a_err_is_last, clock, reset, rsp_if.valid && rsp_if.error_flag,
                rsp_if.last_result)
   // a word without a release reports id zero
   `ASSERT_SAME(a_no_release_id, clock, reset, rsp_if.valid && !rsp_if.woken_valid,
                rsp_if.woken_id == '0)

endmodule
